/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the RTL datapath; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/rrip_pcb_pkg.sv */
// ----------------------------------------------------------------------------
// RRIP replacer package
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrip_pcb_pkg;

    localparam logic [1:0] RRPV_TOP     = 2'd3;
    localparam logic [9:0] SEL_TOP      = 10'd1023;
    localparam logic [9:0] SEL_MID      = 10'd511;
    localparam logic [3:0] CONF_TOP     = 4'd15;
    localparam logic [3:0] CONF_START   = 4'd7;
    localparam logic [3:0] CONF_LOW_MAX = 4'd4;

    localparam logic [10:0] STRIDE_RESET    = 11'd32;
    localparam logic [10:0] STRIDE_MIN      = 11'd2;
    localparam logic [15:0] FIRST_LEN_RESET = 16'd10000;
    localparam logic [15:0] LONG_LEN_RESET  = 16'd30000;

    // Configuration register indexes.
    localparam logic [1:0] REG_STRIDE    = 2'd0;
    localparam logic [1:0] REG_FIRST_LEN = 2'd1;
    localparam logic [1:0] REG_LONG_LEN  = 2'd2;

    // Epoch measurement states.
    localparam logic [1:0] EP_FIRST  = 2'd0;
    localparam logic [1:0] EP_TRIAL  = 2'd1;
    localparam logic [1:0] EP_BYPASS = 2'd2;
    localparam logic [1:0] EP_PLAIN  = 2'd3;

    // Bits of the set number fed through the remainder unit.
    localparam int unsigned DIV_STEPS = 11;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic div_step;
        logic exec;
        logic mul;
        logic cmp;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic need_decide;
    } sts_t;

endpackage

/* src/rrip_pcb_ctrl.sv */
// ----------------------------------------------------------------------------
// RRIP replacer controller
// Sequences clearing, remainder steps, execution and the epoch decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrip_pcb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rrip_pcb_pkg::sts_t  sts,
    output logic                busy,
    output rrip_pcb_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = sts.need_decide ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign cmd.load     = (state_reg == S_IDLE) && start;
    assign cmd.clr_step = (state_reg == S_CLEAR);
    assign cmd.div_step = (state_reg == S_DIV) && !sts.div_done;
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.mul      = (state_reg == S_MUL);
    assign cmd.cmp      = (state_reg == S_CMP);

endmodule

/* src/rrip_pcb_dp.sv */
// ----------------------------------------------------------------------------
// RRIP replacer datapath
// RRPV and confidence memories, leader-set remainder unit, victim and
// insertion logic, set-dueling selector and epoch measurement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrip_pcb_dp
#(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int TABLE_ENTRIES = 16384
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rrip_pcb_pkg::cmd_t  cmd,
    output rrip_pcb_pkg::sts_t  sts,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [15:0]         cfg_wdata,
    input  logic                mode,
    input  logic [10:0]         set_index,
    input  logic [4:0]          way_index,
    input  logic [13:0]         pc_low,
    input  logic                is_writeback,
    input  logic                was_hit,
    input  logic [31:0]         instr_count,
    input  logic [31:0]         cycle_count,
    output logic                done,
    output logic [4:0]          victim_way
);

    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int TAB_W     = $clog2(TABLE_ENTRIES);
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int ROW_W     = 2 * NUM_WAYS;
    localparam int CLR_DEPTH = (NUM_SETS > TABLE_ENTRIES) ? NUM_SETS : TABLE_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // Configuration registers
    logic [10:0] stride_reg;
    logic [15:0] first_len_reg;
    logic [15:0] long_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg    <= rrip_pcb_pkg::STRIDE_RESET;
            first_len_reg <= rrip_pcb_pkg::FIRST_LEN_RESET;
            long_len_reg  <= rrip_pcb_pkg::LONG_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rrip_pcb_pkg::REG_STRIDE:    stride_reg    <= cfg_wdata[10:0];
                rrip_pcb_pkg::REG_FIRST_LEN: first_len_reg <= cfg_wdata;
                rrip_pcb_pkg::REG_LONG_LEN:  long_len_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Addresses from the incoming transaction
    logic [15:0]      set_ext;
    logic [15:0]      pc_ext;
    logic [SET_W-1:0] set_addr;
    logic [TAB_W-1:0] pc_addr;
    logic [15:0]      set_mod;

    assign set_ext  = {5'd0, set_index};
    assign pc_ext   = {2'd0, pc_low};
    assign set_addr = set_ext[SET_W-1:0];
    assign pc_addr  = pc_ext[TAB_W-1:0];
    assign set_mod  = 16'(set_addr);

    // Transaction payload
    logic             mode_reg;
    logic [SET_W-1:0] set_reg;
    logic [4:0]       way_reg;
    logic [TAB_W-1:0] pc_reg;
    logic             wb_reg;
    logic             hit_reg;
    logic [31:0]      icnt_reg;
    logic [31:0]      ccnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            set_reg  <= set_addr;
            way_reg  <= way_index;
            pc_reg   <= pc_addr;
            wb_reg   <= is_writeback;
            hit_reg  <= was_hit;
            icnt_reg <= instr_count;
            ccnt_reg <= cycle_count;
        end
    end

    // Clearing pass counter
    logic [CLR_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_step)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    assign sts.clr_done = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));

    // Memories: one row of RRPVs per set, and {reuse, confidence} per PC entry.
    logic [ROW_W-1:0] rrpv_mem [NUM_SETS];
    logic [4:0]       tab_mem  [TABLE_ENTRIES];
    logic [ROW_W-1:0] row_rd_reg;
    logic [4:0]       tab_rd_reg;
    logic             row_we;
    logic [SET_W-1:0] row_wa;
    logic [ROW_W-1:0] row_wd;
    logic             tab_we;
    logic [TAB_W-1:0] tab_wa;
    logic [4:0]       tab_wd;

    always_ff @(posedge clk)
    begin
        if (row_we)
            rrpv_mem[row_wa] <= row_wd;
        if (cmd.load)
            row_rd_reg <= rrpv_mem[set_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[tab_wa] <= tab_wd;
        if (cmd.load)
            tab_rd_reg <= tab_mem[pc_addr];
    end

    // Bit-serial remainders of the set number by stride and stride plus one
    logic [10:0] dvd_reg;
    logic [11:0] rem1_reg;
    logic [11:0] rem2_reg;
    logic [11:0] d1_reg;
    logic [11:0] d2_reg;
    logic [3:0]  div_cnt_reg;
    logic [10:0] stride_eff;
    logic [11:0] t1;
    logic [11:0] t2;

    assign stride_eff = (stride_reg < rrip_pcb_pkg::STRIDE_MIN) ?
                        rrip_pcb_pkg::STRIDE_MIN : stride_reg;
    assign t1 = {rem1_reg[10:0], dvd_reg[10]};
    assign t2 = {rem2_reg[10:0], dvd_reg[10]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg  <= set_mod[10:0];
            rem1_reg <= '0;
            rem2_reg <= '0;
            d1_reg   <= {1'b0, stride_eff};
            d2_reg   <= {1'b0, stride_eff} + 12'd1;
        end
        else if (cmd.div_step)
        begin
            dvd_reg  <= {dvd_reg[9:0], 1'b0};
            rem1_reg <= (t1 >= d1_reg) ? (t1 - d1_reg) : t1;
            rem2_reg <= (t2 >= d2_reg) ? (t2 - d2_reg) : t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.load)
            div_cnt_reg <= 4'(rrip_pcb_pkg::DIV_STEPS);
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg - 4'd1;
    end

    assign sts.div_done = (div_cnt_reg == 4'd0);

    // Policy state
    logic [9:0]  sel_reg;
    logic [1:0]  epoch_reg;
    logic        bypass_reg;
    logic [15:0] access_reg;
    logic [31:0] start_i_reg;
    logic [31:0] start_c_reg;
    logic [31:0] plain_i_reg;
    logic [31:0] plain_c_reg;
    logic [31:0] byp_i_reg;
    logic [31:0] byp_c_reg;
    logic [63:0] prod1_reg;
    logic [63:0] prod2_reg;

    // Execution logic
    logic             conf_leader;
    logic             mru_leader;
    logic [3:0]       conf;
    logic             reuse;
    logic [1:0]       top;
    logic             any3;
    logic             any2;
    logic             any1;
    logic [4:0]       pick;
    logic [ROW_W-1:0] aged_row;
    logic [ROW_W-1:0] upd_row;
    logic             bypass_hit;
    logic             way_ok;
    logic [WAY_W-1:0] way_sel;
    logic [3:0]       conf_use;
    logic [1:0]       conf_rrpv;
    logic [1:0]       ins_rrpv;
    logic             steer;
    logic [15:0]      cnt_new;
    logic [15:0]      epoch_len;
    logic             ep_end;
    logic [31:0]      di;
    logic [31:0]      dc;
    logic             bypass_phase;

    assign conf_leader = (rem1_reg == 12'd0);
    assign mru_leader  = (rem2_reg == 12'd0);
    assign conf        = tab_rd_reg[3:0];
    assign reuse       = tab_rd_reg[4];
    assign way_ok      = ({1'b0, way_reg} < 6'(NUM_WAYS));
    assign way_sel     = way_reg[WAY_W-1:0];

    always_comb
    begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            any3 = any3 | (row_rd_reg[2*w +: 2] == 2'd3);
            any2 = any2 | (row_rd_reg[2*w +: 2] == 2'd2);
            any1 = any1 | (row_rd_reg[2*w +: 2] == 2'd1);
        end
    end

    assign top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));

    // Ageing lifts every way by the same amount so the oldest reaches the top.
    always_comb
    begin
        pick = 5'd0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            aged_row[2*w +: 2] = row_rd_reg[2*w +: 2] + (rrip_pcb_pkg::RRPV_TOP - top);
            if (row_rd_reg[2*w +: 2] == top)
                pick = 5'(w);
        end
    end

    assign conf_use  = wb_reg ? 4'd0 : conf;
    assign conf_rrpv = (conf_use == rrip_pcb_pkg::CONF_TOP) ? 2'd0 :
                       ((conf_use > rrip_pcb_pkg::CONF_LOW_MAX) ? 2'd2 : 2'd3);
    assign steer     = !wb_reg && reuse;
    assign ins_rrpv  = hit_reg ? 2'd0 :
                       conf_leader ? conf_rrpv :
                       mru_leader ? 2'd0 :
                       (sel_reg > rrip_pcb_pkg::SEL_MID) ? conf_rrpv : 2'd0;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (WAY_W'(w) == way_sel)
                upd_row[2*w +: 2] = ins_rrpv;
            else
                upd_row[2*w +: 2] = row_rd_reg[2*w +: 2];
        end
    end

    assign bypass_hit = (conf == 4'd0) && !wb_reg && bypass_reg &&
                        !conf_leader && !mru_leader;

    always_comb
    begin
        row_we = 1'b0;
        row_wa = set_reg;
        row_wd = upd_row;
        tab_we = 1'b0;
        tab_wa = pc_reg;
        tab_wd = tab_rd_reg;
        if (cmd.clr_step)
        begin
            row_we = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(NUM_SETS));
            row_wa = clr_cnt_reg[SET_W-1:0];
            row_wd = {NUM_WAYS{rrip_pcb_pkg::RRPV_TOP}};
            tab_we = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(TABLE_ENTRIES));
            tab_wa = clr_cnt_reg[TAB_W-1:0];
            tab_wd = {1'b0, rrip_pcb_pkg::CONF_START};
        end
        else if (cmd.exec && !mode_reg && !bypass_hit)
        begin
            row_we = 1'b1;
            row_wd = aged_row;
            tab_we = 1'b1;
            tab_wd = {reuse, (conf != 4'd0) ? (conf - 4'd1) : conf};
        end
        else if (cmd.exec && mode_reg && way_ok)
        begin
            row_we = 1'b1;
            tab_we = hit_reg;
            tab_wd = {1'b1, (conf < rrip_pcb_pkg::CONF_TOP) ? (conf + 4'd1) : conf};
        end
    end

    assign cnt_new   = (access_reg == 16'hFFFF) ? access_reg : (access_reg + 16'd1);
    assign epoch_len = (epoch_reg == rrip_pcb_pkg::EP_FIRST ||
                        epoch_reg == rrip_pcb_pkg::EP_TRIAL) ? first_len_reg : long_len_reg;
    assign ep_end    = way_ok && (cnt_new >= epoch_len);
    assign di        = icnt_reg - start_i_reg;
    assign dc        = ccnt_reg - start_c_reg;

    assign sts.need_decide = mode_reg && ep_end && (epoch_reg != rrip_pcb_pkg::EP_FIRST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg     <= rrip_pcb_pkg::SEL_MID;
            epoch_reg   <= rrip_pcb_pkg::EP_FIRST;
            bypass_reg  <= 1'b0;
            access_reg  <= '0;
            start_i_reg <= '0;
            start_c_reg <= '0;
            plain_i_reg <= '0;
            plain_c_reg <= '0;
            byp_i_reg   <= '0;
            byp_c_reg   <= '0;
        end
        else if (cmd.exec && mode_reg)
        begin
            access_reg <= ep_end ? 16'd0 : cnt_new;
            if (way_ok && !hit_reg && steer)
            begin
                if (conf_leader)
                begin
                    if (sel_reg != 10'd0)
                        sel_reg <= sel_reg - 10'd1;
                end
                else if (mru_leader)
                begin
                    if (sel_reg != rrip_pcb_pkg::SEL_TOP)
                        sel_reg <= sel_reg + 10'd1;
                end
            end
            if (ep_end)
            begin
                start_i_reg <= icnt_reg;
                start_c_reg <= ccnt_reg;
                case (epoch_reg) inside
                    rrip_pcb_pkg::EP_FIRST:
                    begin
                        plain_i_reg <= di;
                        plain_c_reg <= dc;
                        epoch_reg   <= rrip_pcb_pkg::EP_TRIAL;
                        bypass_reg  <= 1'b1;
                    end
                    rrip_pcb_pkg::EP_TRIAL, rrip_pcb_pkg::EP_BYPASS:
                    begin
                        byp_i_reg <= di;
                        byp_c_reg <= dc;
                    end
                    default:
                    begin
                        plain_i_reg <= di;
                        plain_c_reg <= dc;
                    end
                endcase
            end
        end
        else if (cmd.cmp)
        begin
            // Bypass wins when its IPC is higher, compared by cross-multiplying.
            if (prod1_reg > prod2_reg)
            begin
                bypass_reg <= 1'b1;
                epoch_reg  <= rrip_pcb_pkg::EP_BYPASS;
            end
            else
            begin
                bypass_reg <= 1'b0;
                epoch_reg  <= rrip_pcb_pkg::EP_PLAIN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod1_reg <= 64'(byp_i_reg) * 64'(plain_c_reg);
            prod2_reg <= 64'(plain_i_reg) * 64'(byp_c_reg);
        end
    end

    // Result register
    logic       done_reg;
    logic [4:0] victim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.exec && !mode_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && !mode_reg)
            victim_reg <= bypass_hit ? 5'(NUM_WAYS) : pick;
    end

    assign done       = done_reg;
    assign victim_way = victim_reg;

    assign bypass_phase = (epoch_reg == rrip_pcb_pkg::EP_TRIAL) ||
                          (epoch_reg == rrip_pcb_pkg::EP_BYPASS);

    `ASSERT_IMPL(a_exec_after_div, clk, rst_n, cmd.exec, div_cnt_reg == 4'd0)
    `ASSERT_NEXT(a_done_from_victim, clk, rst_n, cmd.exec && !mode_reg, done)
    `ASSERT_IMPL(a_bypass_epoch, clk, rst_n, 1'b1, bypass_reg == bypass_phase)

endmodule

/* src/rrip_pc_confidence_bypass_replacer.sv */
// ----------------------------------------------------------------------------
// RRIP replacer with PC confidence, set dueling and bypass
// Last-level-cache victim selection and hit/fill update unit.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its RRPV and confidence
// memories, holding busy high. A transaction is taken when start is high
// and busy is low; it then latches its inputs and reads both memories,
// runs eleven steps of the bit-serial unit that finds the leader-set
// remainders, passes a state in which that unit reports completion, and
// executes. An update that closes an epoch calling for an IPC decision
// then adds a multiply step and a compare step. A victim request returns
// victim_way with done high for exactly one cycle, the cycle after
// execution; the receiver cannot stall it. Updates return nothing.
// NUM_SETS and TABLE_ENTRIES must be powers of two.
`timescale 1ns / 1ps

module rrip_pc_confidence_bypass_replacer
#(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int TABLE_ENTRIES = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        mode,
    input  logic [10:0] set_index,
    input  logic [4:0]  way_index,
    input  logic [13:0] pc_low,
    input  logic        is_writeback,
    input  logic        was_hit,
    input  logic [31:0] instr_count,
    input  logic [31:0] cycle_count,
    output logic        done,
    output logic [4:0]  victim_way
);

    rrip_pcb_pkg::cmd_t cmd;
    rrip_pcb_pkg::sts_t sts;

    rrip_pcb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    rrip_pcb_dp
    #(
        .NUM_SETS      (NUM_SETS),
        .NUM_WAYS      (NUM_WAYS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .mode         (mode),
        .set_index    (set_index),
        .way_index    (way_index),
        .pc_low       (pc_low),
        .is_writeback (is_writeback),
        .was_hit      (was_hit),
        .instr_count  (instr_count),
        .cycle_count  (cycle_count),
        .done         (done),
        .victim_way   (victim_way)
    );

endmodule
